@@ sv/sv39ptw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Sv39 page table walker: widths, codes and shared types.
// Used by the channel interfaces and by every module of the walker.
package sv39ptw_pkg;

	localparam int PAGE_SHIFT  = 12;
	localparam int INDEX_BITS  = 9;
	localparam int NUM_LEVELS  = 4;
	localparam int VA_W        = 39;
	localparam int PPN_W       = 44;
	localparam int PA_W        = 56;
	localparam int PTE_W       = 64;
	localparam int PTE_PPN_LSB = 10;
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_U_BIT   = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [1:0] TOP_LEVEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_PAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_USER    = 2'd1;

	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_RESPONSE  = 1'b1
	} op_t;

	typedef enum logic {
		KIND_READ = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_INTER_INVALID = 2'd1,
		ST_LEAF_INVALID  = 2'd2,
		ST_LEAF_NOT_USER = 2'd3
	} status_t;

	typedef struct packed {
		logic [PPN_W-1:0] root_table_page;
		logic             require_user;
	} cfg_t;

	typedef struct packed {
		kind_t           kind;
		logic [PA_W-1:0] read_addr;
		logic [PA_W-1:0] phys_addr;
		status_t         status;
	} result_t;

endpackage

@@ sv/sv39ptw_cmd_if.sv @@
`timescale 1ns / 1ps
// Input channel of the walker: translate requests and PTE read responses.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_cmd_if;
	import sv39ptw_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [VA_W-1:0]        virt_addr;
	logic [PTE_W-1:0]       pte_word;

	modport source (output valid, output op, output virt_addr, output pte_word,
		input ready);
	modport sink (input valid, input op, input virt_addr, input pte_word,
		output ready);
endinterface

@@ sv/sv39ptw_result_if.sv @@
`timescale 1ns / 1ps
// Output channel of the walker: memory read requests and finished walks.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_result_if;
	import sv39ptw_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [PA_W-1:0]        read_addr;
	logic [PA_W-1:0]        phys_addr;
	logic [1:0]             status;

	modport source (output valid, output kind, output read_addr, output phys_addr,
		output status, input ready);
	modport sink (input valid, input kind, input read_addr, input phys_addr,
		input status, output ready);
endinterface

@@ sv/sv39ptw_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel of the walker: register index and write data.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_cfg_if;
	import sv39ptw_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/sv39ptw_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration registers of the walker: root table page and user check enable.
// Depends on sv39ptw_pkg and sv39ptw_cfg_if.
module sv39ptw_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	sv39ptw_cfg_if.sink           cfg,
	output sv39ptw_pkg::cfg_t     cfg_out
);
	import sv39ptw_pkg::*;

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.root_table_page <= '0;
			cfg_q.require_user    <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ROOT_TABLE_PAGE: cfg_q.root_table_page <= cfg.data[PPN_W-1:0];
				CFG_REQUIRE_USER:    cfg_q.require_user    <= cfg.data[0];
				default: ;
			endcase
		end
	end
endmodule

@@ sv/sv39ptw_walk.sv @@
`timescale 1ns / 1ps
// Walk state and single-pass step logic: one accepted beat gives at most one result.
// Depends on sv39ptw_pkg.
module sv39ptw_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          beat,
	input  logic                          op,
	input  logic [sv39ptw_pkg::VA_W-1:0]  virt_addr,
	input  logic [sv39ptw_pkg::PTE_W-1:0] pte_word,
	input  sv39ptw_pkg::cfg_t             cfg,
	output logic                          res_push,
	output sv39ptw_pkg::result_t          res
);
	import sv39ptw_pkg::*;

	localparam int VPN_W = NUM_LEVELS * INDEX_BITS;

	logic            busy_q, busy_d;
	logic [1:0]      level_q, level_d;
	logic [VA_W-1:0] va_q, va_d;
	logic [PPN_W-1:0] pte_ppn;
	logic            pte_v, pte_u;

	function automatic logic [PA_W-1:0] pte_addr(input logic [PPN_W-1:0] ppn,
		input logic [VA_W-1:0] va, input logic [1:0] level);
		logic [VPN_W-1:0]      vpn;
		logic [INDEX_BITS-1:0] idx;
		vpn = {{(VPN_W - (VA_W - PAGE_SHIFT)){1'b0}}, va[VA_W-1:PAGE_SHIFT]};
		idx = vpn[level * INDEX_BITS +: INDEX_BITS];
		return {ppn, idx, 3'b000};
	endfunction

	assign pte_ppn = pte_word[PTE_PPN_LSB + PPN_W - 1:PTE_PPN_LSB];
	assign pte_v   = pte_word[PTE_V_BIT];
	assign pte_u   = pte_word[PTE_U_BIT];

	always_comb begin
		busy_d   = busy_q;
		level_d  = level_q;
		va_d     = va_q;
		res_push = 1'b0;
		res      = '0;
		if (beat) begin
			if (op == OP_TRANSLATE) begin
				if (!busy_q) begin
					va_d          = virt_addr;
					level_d       = TOP_LEVEL;
					busy_d        = 1'b1;
					res_push      = 1'b1;
					res.kind      = KIND_READ;
					res.read_addr = pte_addr(cfg.root_table_page, virt_addr, TOP_LEVEL);
				end
			end else if (busy_q) begin
				res_push = 1'b1;
				if (level_q != 2'd0) begin
					if (!pte_v) begin
						busy_d     = 1'b0;
						res.kind   = KIND_DONE;
						res.status = ST_INTER_INVALID;
					end else begin
						level_d       = level_q - 2'd1;
						res.kind      = KIND_READ;
						res.read_addr = pte_addr(pte_ppn, va_q, level_q - 2'd1);
					end
				end else begin
					busy_d   = 1'b0;
					res.kind = KIND_DONE;
					if (!pte_v) begin
						res.status = ST_LEAF_INVALID;
					end else if (cfg.require_user && !pte_u) begin
						res.status = ST_LEAF_NOT_USER;
					end else begin
						res.phys_addr = {pte_ppn, va_q[PAGE_SHIFT-1:0]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			level_q <= 2'd0;
			va_q    <= '0;
		end else begin
			busy_q  <= busy_d;
			level_q <= level_d;
			va_q    <= va_d;
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		beat && op == OP_TRANSLATE && !busy_q |=> busy_q && level_q == TOP_LEVEL)
		else $error("translate beat did not start a walk");
	a_leaf_ends: assert property (@(posedge clk) disable iff (!arst_n)
		beat && op == OP_RESPONSE && busy_q && level_q == 2'd0 |=> !busy_q)
		else $error("leaf response did not end the walk");
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		beat && op == OP_RESPONSE && !busy_q |-> !res_push)
		else $error("response while idle produced a result");
endmodule

@@ sv/sv39ptw_out_skid.sv @@
`timescale 1ns / 1ps
// Output register plus skid register between the step logic and the result channel.
// Depends on sv39ptw_pkg and sv39ptw_result_if.
module sv39ptw_out_skid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sv39ptw_pkg::result_t  push_data,
	output logic                  can_push,
	sv39ptw_result_if.source      result
);
	import sv39ptw_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop              = out_valid_q && result.ready;
	assign can_push         = !skid_valid_q;
	assign result.valid     = out_valid_q;
	assign result.kind      = out_q.kind;
	assign result.read_addr = out_q.read_addr;
	assign result.phys_addr = out_q.phys_addr;
	assign result.status    = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q && out_q == $past(skid_q))
		else $error("skid entry lost on drain");
endmodule

@@ sv/sv39ptw_top.sv @@
`timescale 1ns / 1ps
// Sv39 page table walker. The cmd channel carries translate requests (op 0)
// and PTE read responses (op 1); the result channel carries PTE read requests
// (kind 0) and finished translations (kind 1) with their status.
// The cfg channel writes the root table page (index 0) and the user check
// enable (index 1); it is always ready and should be used only while idle.
// Each accepted cmd beat is worked by the combinational step logic; its result,
// if any, is registered in the output register, or in the skid register if the
// receiver stalls. One beat can be taken every cycle while the skid is empty.
// A walk takes TOP_LEVEL + 1 responses, fewer if a non-leaf PTE is invalid.
// Translate beats during a walk and responses while idle are taken and dropped.
// A skid register behind the output register lets one more beat be taken while
// the receiver stalls; with both full, cmd.ready drops until a result is taken.
// Reset clears the walk to idle, the root page to zero and sets the user check.
// Depends on sv39ptw_pkg, the channel interfaces and the walker submodules.
module sv39_page_table_walker (
	input  logic              clk,
	input  logic              arst_n,
	sv39ptw_cmd_if.sink       cmd,
	sv39ptw_result_if.source  result,
	sv39ptw_cfg_if.sink       cfg
);
	import sv39ptw_pkg::*;

	cfg_t    cfg_cur;
	result_t res;
	logic    res_push;
	logic    can_push;
	logic    beat;

	assign cmd.ready = can_push;
	assign beat      = cmd.valid && cmd.ready;

	sv39ptw_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	sv39ptw_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.op        (cmd.op),
		.virt_addr (cmd.virt_addr),
		.pte_word  (cmd.pte_word),
		.cfg       (cfg_cur),
		.res_push  (res_push),
		.res       (res)
	);

	sv39ptw_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.can_push  (can_push),
		.result    (result)
	);
endmodule
